// ===== sv/ebes_pkg.sv =====
// Shared constants, types and control structs of the encoder bank event scanner.
package ebes_pkg;

  localparam int NIB_CH         = 16;
  localparam int CHANNELS_DEF   = 16;
  localparam int BANKS_DEF      = 4;
  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [3:0] ENC_MAP [0:15] = '{
    4'd14, 4'd15, 4'd10, 4'd11, 4'd6, 4'd7, 4'd2, 4'd3,
    4'd12, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd0, 4'd1
  };
  localparam logic [3:0] REV_MAP [0:15] = '{
    4'd12, 4'd13, 4'd14, 4'd15, 4'd8, 4'd9, 4'd10, 4'd11,
    4'd4, 4'd5, 4'd6, 4'd7, 4'd0, 4'd1, 4'd2, 4'd3
  };

  localparam int E_MAX       = 400;
  localparam int E_MIN       = 20;
  localparam int FACTOR_NUM  = 160000;
  localparam int FACTOR_DEN  = 60000;
  localparam int Q2_LIM      = FACTOR_NUM - 2 * FACTOR_DEN;
  localparam int Q1_LIM      = FACTOR_NUM - FACTOR_DEN;

  localparam logic [6:0] VAL_MAX  = 7'd127;
  localparam logic [6:0] TOG_MID  = 7'd63;
  localparam logic [7:0] REL_IDLE = 8'd255;
  localparam logic [7:0] REL_UP   = 8'd65;
  localparam logic [7:0] REL_DN   = 8'd63;

  typedef enum logic [1:0] {
    EV_INIT    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_TURN    = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [6:0] abs_v;
    logic [7:0] rel_v;
    logic [6:0] tog2;
    logic [6:0] tog3;
  } entry_t;

  localparam entry_t ENTRY_RST = '{abs_v: 7'd0, rel_v: REL_IDLE, tog2: 7'd0, tog3: 7'd0};

  typedef struct packed {
    logic idle;
    logic accept;
    logic init_rd;
    logic init_ld;
    logic emit_init;
    logic pick;
    logic scan_rd;
    logic scan_ld;
    logic do_btn;
    logic do_turn;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fire;
    logic changed;
    logic init_last;
    logic pend_any;
    logic btn_pend;
    logic turn_pend;
    logic can_emit;
  } ctrl_stat_t;

endpackage

// ===== sv/ebes_if.sv =====
// Handshake channels for frame items and scanner events.
interface ebes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_bits;
  logic [1:0]  bank;
  logic        new_bank;
  logic [31:0] now_time;

  modport source(output valid, frame_bits, bank, new_bank, now_time, input ready);
  modport sink(input valid, frame_bits, bank, new_bank, now_time, output ready);
endinterface

interface ebes_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel;
  logic [3:0] reversed_channel;
  logic [1:0] event_kind;
  logic [6:0] abs_value;
  logic [7:0] rel_value;
  logic [6:0] toggle2;
  logic [6:0] toggle3;
  logic [6:0] button_abs;
  logic [6:0] rotation;
  logic       last;

  modport source(output valid, channel, reversed_channel, event_kind, abs_value, rel_value,
                 toggle2, toggle3, button_abs, rotation, last, input ready);
  modport sink(input valid, channel, reversed_channel, event_kind, abs_value, rel_value,
               toggle2, toggle3, button_abs, rotation, last, output ready);
endinterface

// ===== sv/ebes_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ebes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/ebes_ctrl.sv =====
// Sequencer for init events and the per-nibble scan.
module ebes_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  ebes_pkg::ctrl_stat_t   stat,
  output ebes_pkg::ctrl_cmd_t    cmd
);
  import ebes_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INIT_RD = 9'b000000010,
    S_INIT_LD = 9'b000000100,
    S_INIT_OUT= 9'b000001000,
    S_SCAN    = 9'b000010000,
    S_RD      = 9'b000100000,
    S_LD      = 9'b001000000,
    S_BTN     = 9'b010000000,
    S_TURN    = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.idle   = 1'b1;
        cmd.accept = stat.fire;
        if (stat.fire) begin
          state_next = stat.changed ? S_INIT_RD : S_SCAN;
        end
      end
      S_INIT_RD: begin
        cmd.init_rd = 1'b1;
        state_next  = S_INIT_LD;
      end
      S_INIT_LD: begin
        cmd.init_ld = 1'b1;
        state_next  = S_INIT_OUT;
      end
      S_INIT_OUT: begin
        if (stat.can_emit) begin
          cmd.emit_init = 1'b1;
          state_next    = stat.init_last ? S_SCAN : S_INIT_RD;
        end
      end
      S_SCAN: begin
        cmd.pick   = 1'b1;
        state_next = stat.pend_any ? S_RD : S_IDLE;
      end
      S_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_LD;
      end
      S_LD: begin
        cmd.scan_ld = 1'b1;
        state_next  = stat.btn_pend ? S_BTN : S_TURN;
      end
      S_BTN: begin
        if (stat.can_emit) begin
          cmd.do_btn = 1'b1;
          state_next = stat.turn_pend ? S_TURN : S_SCAN;
        end
      end
      S_TURN: begin
        if (stat.can_emit) begin
          cmd.do_turn = 1'b1;
          state_next  = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== sv/ebes_dp.sv =====
// Datapath: channel state, bank store, turn arithmetic and event register.
module ebes_dp #(
  parameter int CHANNELS   = ebes_pkg::CHANNELS_DEF,
  parameter int BANKS      = ebes_pkg::BANKS_DEF,
  parameter int TIME_WIDTH = ebes_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  ebes_in_if.sink              items,
  ebes_out_if.source           events,
  input  ebes_pkg::ctrl_cmd_t  cmd,
  output ebes_pkg::ctrl_stat_t stat
);
  import ebes_pkg::*;

  localparam int SLOTS  = BANKS * NIB_CH;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int BANK_W = BANKS > 1 ? $clog2(BANKS) : 1;

  logic [63:0]           frame_r;
  logic [BANK_W-1:0]     bank_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [3:0]            idx;
  logic [NIB_CH-1:0]     btn_p, turn_p;

  logic [3:0]            last_nib [NIB_CH];
  logic [NIB_CH-1:0]     btn_lvl, phase_a;
  logic [TIME_WIDTH-1:0] ltt [NIB_CH];
  logic [6:0]            rot [NIB_CH];
  logic [SLOTS-1:0]      slot_valid;

  entry_t                ent, ent_next, rdata;
  logic                  rd_valid;
  logic [17:0]           e2;
  logic [SLOT_W-1:0]     slot_r;

  logic                  re, we;
  logic [SLOT_W-1:0]     raddr;
  logic [BANK_W-1:0]     bank_eff;
  logic [NIB_CH-1:0]     chg, btn_new, turn_new;
  logic [3:0]            pick_j, ch;
  logic [NIB_CH-1:0]     rest;
  logic [3:0]            nib;
  logic                  neg;
  logic [TIME_WIDTH-1:0] diff;
  logic [8:0]            e_cl;
  logic [2:0]            step;
  logic [6:0]            rot_new;
  logic                  can_emit;

  assign items.ready = cmd.idle;
  assign can_emit    = !events.valid || events.ready;
  assign bank_eff    = (32'(items.bank) < BANKS) ? BANK_W'(items.bank) : '0;
  assign ch          = ENC_MAP[idx];
  assign nib         = frame_r[4*idx +: 4];
  assign neg         = nib[0] != nib[1];

  always_comb begin
    for (int j = 0; j < NIB_CH; j++) begin
      chg[j]      = (j < CHANNELS) && (items.frame_bits[4*j +: 4] != last_nib[j]);
      btn_new[j]  = chg[j] && ((|items.frame_bits[4*j+2 +: 2]) != btn_lvl[ENC_MAP[j]]);
      turn_new[j] = chg[j] && (items.frame_bits[4*j+1] != phase_a[ENC_MAP[j]]);
    end
  end

  always_comb begin
    pick_j = '0;
    for (int j = NIB_CH - 1; j >= 0; j--) begin
      if (btn_p[j] || turn_p[j]) begin
        pick_j = 4'(j);
      end
    end
  end

  always_comb begin
    rest      = btn_p | turn_p;
    rest[idx] = 1'b0;
  end

  assign stat.fire      = items.valid && items.ready;
  assign stat.changed   = items.new_bank;
  assign stat.init_last = idx == 4'(CHANNELS - 1);
  assign stat.pend_any  = |(btn_p | turn_p);
  assign stat.btn_pend  = btn_p[idx];
  assign stat.turn_pend = turn_p[idx];
  assign stat.can_emit  = can_emit;

  assign re    = cmd.init_rd || cmd.scan_rd;
  assign raddr = SLOT_W'({bank_r, (cmd.init_rd ? idx : ch)});
  assign we    = cmd.do_btn || cmd.do_turn;

  ebes_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOTS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (slot_r),
    .wdata (ent_next),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    diff = now_r - ltt[ch];
    if (diff > TIME_WIDTH'(E_MAX)) begin
      e_cl = 9'(E_MAX);
    end else if (diff < TIME_WIDTH'(E_MIN)) begin
      e_cl = 9'(E_MIN);
    end else begin
      e_cl = diff[8:0];
    end
  end

  always_comb begin
    priority if (e2 <= 18'(Q2_LIM)) begin
      step = 3'd4;
    end else if (e2 <= 18'(Q1_LIM)) begin
      step = 3'd3;
    end else begin
      step = 3'd2;
    end
    if (neg) begin
      rot_new = (rot[ch] > 7'(step)) ? rot[ch] - 7'(step) : 7'd0;
    end else begin
      rot_new = (8'(rot[ch]) + 8'(step) > 8'(VAL_MAX)) ? VAL_MAX : rot[ch] + 7'(step);
    end
  end

  always_comb begin
    ent_next = ent;
    if (cmd.do_btn && !btn_lvl[ch]) begin
      ent_next.tog2 = (ent.tog2 == 7'd0) ? VAL_MAX : 7'd0;
      priority if (ent.tog3 == 7'd0) begin
        ent_next.tog3 = TOG_MID;
      end else if (ent.tog3 == TOG_MID) begin
        ent_next.tog3 = VAL_MAX;
      end else begin
        ent_next.tog3 = 7'd0;
      end
    end
    if (cmd.do_turn) begin
      if (neg) begin
        ent_next.abs_v = (ent.abs_v == 7'd0) ? 7'd0 : ent.abs_v - 7'd1;
        ent_next.rel_v = (ent.rel_v == REL_IDLE) ? REL_DN : ent.rel_v - 8'd1;
      end else begin
        ent_next.abs_v = (ent.abs_v == VAL_MAX) ? VAL_MAX : ent.abs_v + 7'd1;
        ent_next.rel_v = (ent.rel_v == REL_IDLE) ? REL_UP : ent.rel_v + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      btn_p      <= '0;
      turn_p     <= '0;
      idx        <= '0;
      btn_lvl    <= '1;
      phase_a    <= '1;
      slot_valid <= '0;
      for (int j = 0; j < NIB_CH; j++) begin
        last_nib[j] <= '0;
        ltt[j]      <= '1;
        rot[j]      <= '0;
      end
    end else begin
      if (cmd.accept) begin
        frame_r <= items.frame_bits;
        bank_r  <= bank_eff;
        now_r   <= items.now_time[TIME_WIDTH-1:0];
        idx     <= '0;
        btn_p   <= btn_new;
        turn_p  <= turn_new;
        for (int j = 0; j < NIB_CH; j++) begin
          if (chg[j]) begin
            last_nib[j]         <= items.frame_bits[4*j +: 4];
            btn_lvl[ENC_MAP[j]] <= |items.frame_bits[4*j+2 +: 2];
            phase_a[ENC_MAP[j]] <= items.frame_bits[4*j+1];
          end
        end
      end
      if (re) begin
        rd_valid <= slot_valid[raddr];
        slot_r   <= raddr;
      end
      if (cmd.init_ld || cmd.scan_ld) begin
        ent <= rd_valid ? rdata : ENTRY_RST;
      end
      if (cmd.scan_rd) begin
        e2 <= 18'(e_cl) * 18'(e_cl);
      end
      if (cmd.emit_init) begin
        idx <= stat.init_last ? 4'd0 : idx + 4'd1;
      end
      if (cmd.pick) begin
        idx <= pick_j;
      end
      if (we) begin
        ent                <= ent_next;
        slot_valid[slot_r] <= 1'b1;
      end
      if (cmd.do_btn) begin
        btn_p[idx] <= 1'b0;
      end
      if (cmd.do_turn) begin
        turn_p[idx] <= 1'b0;
        ltt[ch]     <= now_r;
        rot[ch]     <= rot_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
    end else if (cmd.emit_init || cmd.do_btn || cmd.do_turn) begin
      events.valid <= 1'b1;
    end else if (events.ready) begin
      events.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      events.channel          <= idx;
      events.reversed_channel <= REV_MAP[idx];
      events.event_kind       <= EV_INIT;
      events.abs_value        <= ent.abs_v;
      events.rel_value        <= ent.rel_v;
      events.toggle2          <= ent.tog2;
      events.toggle3          <= ent.tog3;
      events.button_abs       <= 7'd0;
      events.rotation         <= rot[idx];
      events.last             <= stat.init_last && !stat.pend_any;
    end else if (cmd.do_btn || cmd.do_turn) begin
      events.channel          <= ch;
      events.reversed_channel <= REV_MAP[ch];
      events.abs_value        <= ent_next.abs_v;
      events.rel_value        <= ent_next.rel_v;
      events.toggle2          <= ent_next.tog2;
      events.toggle3          <= ent_next.tog3;
      if (cmd.do_turn) begin
        events.event_kind <= EV_TURN;
        events.button_abs <= 7'd0;
        events.rotation   <= rot_new;
        events.last       <= !(|rest);
      end else begin
        events.event_kind <= btn_lvl[ch] ? EV_RELEASE : EV_PRESS;
        events.button_abs <= btn_lvl[ch] ? 7'd0 : VAL_MAX;
        events.rotation   <= rot[ch];
        events.last       <= !turn_p[idx] && !(|rest);
      end
    end
  end
endmodule

// ===== sv/encoder_bank_event_scanner.sv =====
// Top level: scans encoder frames into a serial list of init, button and turn events.
// Sequence: on a bank change, each channel is read, loaded and emitted as an init event;
// then each nibble with a pending button or turn is picked, read, loaded and emits its events.
// An event is emitted only when the event register has room, so the receiver can stall a scan.
// A frame is taken only when the previous one is fully scanned; the event register decouples.
// Reset: synchronous; channel state, store valid bits and the event valid bit are cleared.
module encoder_bank_event_scanner #(
  parameter int CHANNELS   = ebes_pkg::CHANNELS_DEF,
  parameter int BANKS      = ebes_pkg::BANKS_DEF,
  parameter int TIME_WIDTH = ebes_pkg::TIME_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  ebes_in_if.sink    items,
  ebes_out_if.source events
);
  import ebes_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  ebes_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  ebes_dp #(
    .CHANNELS   (CHANNELS),
    .BANKS      (BANKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .events (events),
    .cmd    (cmd),
    .stat   (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !items.ready)
    else $error("frame taken while scan in progress");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_init || cmd.do_btn || cmd.do_turn) |-> stat.can_emit)
    else $error("event overwrites a waiting beat");

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_init, cmd.do_btn, cmd.do_turn}))
    else $error("two events in one cycle");
endmodule

// ===== bench/encoder_bank_event_scanner_chk.sv =====
// Checker: watches frame and event beats, predicts the event list and compares it.
module encoder_bank_event_scanner_chk (
  input  logic       clk,
  input  logic       rst,
  ebes_in_if         items,
  ebes_out_if        events,
  output int         fails,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ebes_pkg::*;

  typedef struct packed {
    logic [3:0] channel;
    logic [3:0] reversed_channel;
    logic [1:0] event_kind;
    logic [6:0] abs_value;
    logic [7:0] rel_value;
    logic [6:0] toggle2;
    logic [6:0] toggle3;
    logic [6:0] button_abs;
    logic [6:0] rotation;
    logic       last;
  } scan_event_t;

  scan_event_t event_q[$];

  logic [3:0]  last_nib [16];
  logic        btn_lvl [16];
  logic [1:0]  ph_prev [16];
  logic [31:0] turn_t [16];
  logic [6:0]  rot_st [16];
  logic [6:0]  abs_st [64];
  logic [7:0]  rel_st [64];
  logic [6:0]  t2_st [64];
  logic [6:0]  t3_st [64];

  assign pending = event_q.size();

  function automatic scan_event_t make_event(int ch, int slot, ev_kind_t k, logic [6:0] babs);
    scan_event_t e;
    e.channel = ch[3:0];
    e.reversed_channel = REV_MAP[ch];
    e.event_kind = k;
    e.abs_value = abs_st[slot];
    e.rel_value = rel_st[slot];
    e.toggle2 = t2_st[slot];
    e.toggle3 = t3_st[slot];
    e.button_abs = babs;
    e.rotation = rot_st[ch];
    e.last = 1'b0;
    return e;
  endfunction

  task automatic predict_frame(logic [63:0] fb, logic [1:0] bk, logic chg, logic [31:0] now);
    int n, ch, slot, delta, v, step;
    logic [3:0] nib;
    logic lvl, a, b;
    logic [31:0] el, factor;
    n = 0;
    if (chg) begin
      for (int j = 0; j < 16; j++) begin
        event_q.push_back(make_event(j, bk * 16 + j, EV_INIT, 7'd0));
        n++;
      end
    end
    for (int j = 0; j < 16; j++) begin
      nib = fb[4*j +: 4];
      ch = ENC_MAP[j];
      slot = bk * 16 + ch;
      if (nib != last_nib[j]) begin
        last_nib[j] = nib;
        lvl = |nib[3:2];
        a = nib[1];
        b = nib[0];
        if (lvl != btn_lvl[ch]) begin
          btn_lvl[ch] = lvl;
          if (!lvl) begin
            t2_st[slot] = (t2_st[slot] == 0) ? VAL_MAX : 7'd0;
            t3_st[slot] = (t3_st[slot] == 0) ? TOG_MID : (t3_st[slot] == TOG_MID) ? VAL_MAX : 7'd0;
            event_q.push_back(make_event(ch, slot, EV_PRESS, VAL_MAX));
          end else begin
            event_q.push_back(make_event(ch, slot, EV_RELEASE, 7'd0));
          end
          n++;
        end
        if (a != ph_prev[ch][1]) begin
          delta = (b != a) ? -1 : 1;
          el = now - turn_t[ch];
          if (el > E_MAX) el = E_MAX;
          if (el < E_MIN) el = E_MIN;
          factor = (FACTOR_NUM - el * el) / FACTOR_DEN + 1;
          turn_t[ch] = now;
          step = delta * (1 + int'(factor));
          v = int'(rot_st[ch]) + step;
          rot_st[ch] = (v < 0) ? 7'd0 : (v > 127) ? 7'd127 : v[6:0];
          v = int'(abs_st[slot]) + delta;
          abs_st[slot] = (v < 0) ? 7'd0 : (v > 127) ? 7'd127 : v[6:0];
          if (rel_st[slot] == REL_IDLE) rel_st[slot] = (delta > 0) ? REL_UP : REL_DN;
          else rel_st[slot] = rel_st[slot] + ((delta > 0) ? 8'd1 : 8'd255);
          event_q.push_back(make_event(ch, slot, EV_TURN, 7'd0));
          n++;
        end
        ph_prev[ch] = {a, b};
      end
    end
    if (n > 0) event_q[event_q.size() - 1].last = 1'b1;
  endtask

  scan_event_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      fails <= 0;
      event_q.delete();
      for (int k = 0; k < 16; k++) begin
        last_nib[k] = 0; btn_lvl[k] = 1; ph_prev[k] = 2'b11;
        turn_t[k] = '1; rot_st[k] = 0;
      end
      for (int k = 0; k < 64; k++) begin
        abs_st[k] = 0; rel_st[k] = REL_IDLE; t2_st[k] = 0; t3_st[k] = 0;
      end
    end else begin
      if (events.valid && events.ready) begin
        got = '{events.channel, events.reversed_channel, events.event_kind, events.abs_value,
                events.rel_value, events.toggle2, events.toggle3, events.button_abs,
                events.rotation, events.last};
        if (event_q.size() == 0) begin
          $display("%0t: unexpected event beat, expected none, actual %h", $time, got);
          fails <= fails + 1;
        end else begin
          want = event_q.pop_front();
          if (got !== want) begin
            $display("%0t: event mismatch, expected %h, actual %h", $time, want, got);
            fails <= fails + 1;
          end
        end
      end
      if (items.valid && items.ready)
        predict_frame(items.frame_bits, items.bank, items.new_bank, items.now_time);
    end
  end
endmodule

// ===== bench/encoder_bank_event_scanner_tb.sv =====
// Testbench top: drives frames with idling phases and reports the verdict.
module encoder_bank_event_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  int fails, pending;
  int cycles = 0;
  int phase = 0;
  logic [63:0] cur;
  logic [31:0] tnow;

  ebes_in_if  items();
  ebes_out_if events();

  encoder_bank_event_scanner dut (.clk(clk), .rst(rst), .items(items), .events(events));
  encoder_bank_event_scanner_chk chk (.clk(clk), .rst(rst), .items(items), .events(events),
                                      .fails(fails), .pending(pending));

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls by phase
  always @(posedge clk) begin
    if (rst) events.ready <= 1'b0;
    else case (phase)
      2: events.ready <= ($urandom_range(99) >= 70);
      3: events.ready <= ($urandom_range(99) >= 6);
      default: events.ready <= 1'b1;
    endcase
  end

  initial begin
    items.valid = 0; items.frame_bits = 0; items.bank = 0;
    items.new_bank = 0; items.now_time = 0;
  end

  task automatic send(logic [63:0] fb, logic [1:0] bk, logic chg, logic [31:0] t);
    if (phase == 1) begin
      while ($urandom_range(99) < 70) begin
        items.valid <= 1'b0;
        @(posedge clk);
      end
    end else if (phase == 3) begin
      while ($urandom_range(99) < 6) begin
        items.valid <= 1'b0;
        @(posedge clk);
      end
    end
    items.valid <= 1'b1;
    items.frame_bits <= fb;
    items.bank <= bk;
    items.new_bank <= chg;
    items.now_time <= t;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  // one to three nibbles moved by a quadrature step, button or noise
  function automatic logic [63:0] mutate(logic [63:0] f);
    int j;
    logic [3:0] n;
    logic [1:0] g;
    for (int k = $urandom_range(1, 3); k > 0; k--) begin
      j = $urandom_range(15);
      n = f[4*j +: 4];
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          g = n[1:0];
          g = ($urandom_range(1)) ? {g[0], ~g[1]} : {~g[0], g[1]};
          n[1:0] = g;
        end
        5, 6: n[3:2] = (n[3:2] == 0) ? 2'b11 : 2'b00;
        7: n[3] = ~n[3];
        default: n = 4'($urandom_range(15));
      endcase
      f[4*j +: 4] = n;
    end
    return f;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tnow = 32'd1000;
    send(64'h0, 2'd0, 1'b1, tnow);
    send('1, 2'd0, 1'b0, tnow + 5);
    send(64'h0, 2'd3, 1'b1, 32'hFFFF_FFFF);
    send(64'h2222_2222_2222_2222, 2'd3, 1'b0, 32'd0);
    send(64'h3333_3333_3333_3333, 2'd3, 1'b0, 32'd10);
    send(64'h1111_1111_1111_1111, 2'd3, 1'b0, 32'd500);
    send(64'h0000_0000_0000_0000, 2'd3, 1'b0, 32'd700);
    send(64'h8888_8888_8888_8888, 2'd1, 1'b1, 32'd900);
    send(64'hCCCC_CCCC_CCCC_CCCC, 2'd1, 1'b0, 32'd950);
    send(64'hCCCC_CCCC_CCCC_CCCC, 2'd2, 1'b0, 32'd960);
    send(64'h0000_0000_0000_0000, 2'd2, 1'b1, 32'd970);
    for (int k = 0; k < 8; k++) send(64'hCCCC_CCCC_CCCC_CCCC ^ {16{k[0], 1'b0, k[0], 1'b0}},
                                     2'd2, 1'b0, 32'd1000 + k * 15);
    cur = 64'hCCCC_CCCC_CCCC_CCCC;
    for (int k = 0; k < 80; k++) begin
      cur = {cur[62:0], cur[63]};
      cur[1:0] = ~cur[1:0];
      send(cur, 2'd0, 1'b0, 32'd2000 + k * 25);
    end
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (phase = 0; phase < 4; phase++) begin
      for (int k = 0; k < 80; k++) begin
        if ($urandom_range(9) == 0) cur = {$urandom, $urandom};
        else cur = mutate(cur);
        tnow = tnow + (($urandom_range(3) == 0) ? $urandom : $urandom_range(450));
        send(cur, 2'($urandom_range(3)), ($urandom_range(19) == 0), tnow);
      end
    end
    phase = 0;
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
